// ----- src/aabb_collision_resolve_assert.svh -----
// ----------------------------------------------------------------------------
// aabb collision resolve assertion macros
// Concurrent assertion helpers used by the top-level RTL file, clocked on a rising
// edge and disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef AABB_COLLISION_RESOLVE_ASSERT_SVH
`define AABB_COLLISION_RESOLVE_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every enabled edge
`define ACR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("aabb collision resolve assertion failed");

// expression must never be true
`define ACR_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	`ACR_ASSERT(lbl, clk, rst_n, !(expr))

`else

`define ACR_ASSERT(lbl, clk, rst_n, prop)
`define ACR_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ----- src/acr_pkg.sv -----
// ----------------------------------------------------------------------------
// acr_pkg
// Widths, stream packing offsets, side codes and stage payload types for the
// box collision resolver.
// ----------------------------------------------------------------------------
package acr_pkg;

	localparam int CW = 24;          // coordinate width, signed fixed point
	localparam int FB = 8;           // fraction bits
	localparam int DW = CW + 2;      // penetration depth width, signed
	localparam int PW = DW + FB;     // rounded push width, unsigned
	localparam int SW = PW + 2;      // position sum width before saturation

	// input stream packing, first field lowest
	localparam int O_X  = 0;
	localparam int O_Y  = O_X + CW;
	localparam int O_W  = O_Y + CW;
	localparam int O_H  = O_W + CW - 1;
	localparam int O_VX = O_H + CW - 1;
	localparam int O_VY = O_VX + CW;
	localparam int O_WX = O_VY + CW;
	localparam int O_WY = O_WX + CW;
	localparam int O_WW = O_WY + CW;
	localparam int O_WH = O_WW + CW - 1;
	localparam int IN_BITS     = O_WH + CW - 1;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = 4 * CW + 3;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [PW-1:0] ROUND_ADD = PW'((longint'(1) << FB) - 1);
	localparam logic signed [SW-1:0] SAT_HI = SW'((longint'(1) << (CW - 1)) - 1);
	localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

	typedef enum logic [2:0] {
		SIDE_NONE   = 3'd0,
		SIDE_TOP    = 3'd1,
		SIDE_BOTTOM = 3'd2,
		SIDE_LEFT   = 3'd3,
		SIDE_RIGHT  = 3'd4
	} side_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic        [CW-2:0] w;
		logic        [CW-2:0] h;
		logic signed [CW-1:0] vx;
		logic signed [CW-1:0] vy;
		logic signed [CW-1:0] wx;
		logic signed [CW-1:0] wy;
		logic        [CW-2:0] ww;
		logic        [CW-2:0] wh;
	} req_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] vx;
		logic signed [CW-1:0] vy;
		logic signed [DW-1:0] dt;
		logic signed [DW-1:0] db;
		logic signed [DW-1:0] dl;
		logic signed [DW-1:0] dr;
	} depth_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] vx;
		logic signed [CW-1:0] vy;
		side_t                side;
		logic        [PW-1:0] push;
	} pick_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] vx;
		logic signed [CW-1:0] vy;
		side_t                side;
	} res_t;

endpackage

// ----- src/acr_depth.sv -----
// ----------------------------------------------------------------------------
// acr_depth
// First stage: forms the four penetration depths of the moving box against
// the fixed box and registers them with the pass-through fields.
// ----------------------------------------------------------------------------
module acr_depth (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  acr_pkg::req_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output acr_pkg::depth_t out_data
);
	import acr_pkg::*;

	logic   valid_s1;
	depth_t data_s1;
	depth_t nxt;

	function automatic logic [DW-1:0] sx(input logic [CW-1:0] v);
		return {{(DW-CW){v[CW-1]}}, v};
	endfunction

	function automatic logic [DW-1:0] zx(input logic [CW-2:0] v);
		return {{(DW-CW+1){1'b0}}, v};
	endfunction

	always_comb begin
		nxt.x  = in_data.x;
		nxt.y  = in_data.y;
		nxt.vx = in_data.vx;
		nxt.vy = in_data.vy;
		nxt.dt = sx(in_data.y) + zx(in_data.h) - sx(in_data.wy);
		nxt.db = sx(in_data.wy) + zx(in_data.wh) - sx(in_data.y);
		nxt.dl = sx(in_data.x) + zx(in_data.w) - sx(in_data.wx);
		nxt.dr = sx(in_data.wx) + zx(in_data.ww) - sx(in_data.x);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ----- src/acr_select.sv -----
// ----------------------------------------------------------------------------
// acr_select
// Second stage: picks the strictly smallest depth, rounds it up to whole
// units and clears the velocity component heading into the fixed box.
// ----------------------------------------------------------------------------
module acr_select (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  acr_pkg::depth_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output acr_pkg::pick_t  out_data
);
	import acr_pkg::*;

	logic                 valid_s2;
	pick_t                data_s2;
	pick_t                nxt;
	logic signed [DW-1:0] depth;
	logic        [PW-1:0] rounded;

	function automatic logic smallest(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b, input logic signed [DW-1:0] c,
			input logic signed [DW-1:0] d);
		return (a < b) && (a < c) && (a < d);
	endfunction

	always_comb begin
		nxt.x  = in_data.x;
		nxt.y  = in_data.y;
		nxt.vx = in_data.vx;
		nxt.vy = in_data.vy;
		depth  = '0;
		if (smallest(in_data.dt, in_data.db, in_data.dl, in_data.dr)) begin
			nxt.side = SIDE_TOP;
			depth    = in_data.dt;
			if (in_data.vy > 0) nxt.vy = '0;
		end else if (smallest(in_data.db, in_data.dt, in_data.dl, in_data.dr)) begin
			nxt.side = SIDE_BOTTOM;
			depth    = in_data.db;
			if (in_data.vy < 0) nxt.vy = '0;
		end else if (smallest(in_data.dl, in_data.dr, in_data.dt, in_data.db)) begin
			nxt.side = SIDE_LEFT;
			depth    = in_data.dl;
			if (in_data.vx > 0) nxt.vx = '0;
		end else if (smallest(in_data.dr, in_data.dl, in_data.dt, in_data.db)) begin
			nxt.side = SIDE_RIGHT;
			depth    = in_data.dr;
			if (in_data.vx < 0) nxt.vx = '0;
		end else begin
			nxt.side = SIDE_NONE;
		end
		// ceiling to whole units, no push without overlap
		rounded  = {{(PW-DW){1'b0}}, depth} + ROUND_ADD;
		nxt.push = (depth > 0) ? (rounded & ~ROUND_ADD) : '0;
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ----- src/acr_apply.sv -----
// ----------------------------------------------------------------------------
// acr_apply
// Third stage: moves the box out along the chosen side and saturates the
// new position to the coordinate range; this register drives the result.
// ----------------------------------------------------------------------------
module acr_apply (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  acr_pkg::pick_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output acr_pkg::res_t  out_data
);
	import acr_pkg::*;

	logic                 valid_s3;
	res_t                 data_s3;
	res_t                 nxt;
	logic                 vert;
	logic                 back;
	logic signed [CW-1:0] base;
	logic signed [SW-1:0] base_ext;
	logic signed [SW-1:0] push_ext;
	logic signed [SW-1:0] sum;
	logic signed [CW-1:0] clamped;

	always_comb begin
		vert     = (in_data.side == SIDE_TOP) || (in_data.side == SIDE_BOTTOM);
		back     = (in_data.side == SIDE_TOP) || (in_data.side == SIDE_LEFT);
		base     = vert ? in_data.y : in_data.x;
		base_ext = {{(SW-CW){base[CW-1]}}, base};
		push_ext = {2'b00, in_data.push};
		sum      = back ? (base_ext - push_ext) : (base_ext + push_ext);
		if (sum > SAT_HI) begin
			clamped = SAT_HI[CW-1:0];
		end else if (sum < SAT_LO) begin
			clamped = SAT_LO[CW-1:0];
		end else begin
			clamped = sum[CW-1:0];
		end
		nxt.x    = (in_data.side == SIDE_LEFT || in_data.side == SIDE_RIGHT) ?
			clamped : in_data.x;
		nxt.y    = vert ? clamped : in_data.y;
		nxt.vx   = in_data.vx;
		nxt.vy   = in_data.vy;
		nxt.side = in_data.side;
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3 <= nxt;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

// ----- src/aabb_collision_resolve.sv -----
// ----------------------------------------------------------------------------
// aabb_collision_resolve
// Resolves one moving axis-aligned box against one fixed box per request, in
// signed Q15.8 fixed point. The four penetration depths are formed, the side
// with the strictly smallest depth is reported (none on a tie), the velocity
// component heading into that side is cleared and the box is pushed out by
// the depth rounded up to whole units, saturated to the coordinate range.
// Throughput is one request per clock unless the output stalls; the three
// register stages are depths, side pick and rounding, push and saturation.
// The stages stall together from the output backward, so tready on the input
// follows the fill state of the three stages and the downstream tready.
// ----------------------------------------------------------------------------
module aabb_collision_resolve (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// mover_x, mover_y, mover_w, mover_h, mover_vx, mover_vy,
	// wall_x, wall_y, wall_w, wall_h, zero pad
	input  logic [acr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// new_x, new_y, new_vx, new_vy, hit_side, zero pad
	output logic [acr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import acr_pkg::*;

	`include "aabb_collision_resolve_assert.svh"

	req_t   req;
	depth_t depth_data;
	pick_t  pick_data;
	res_t   res;
	logic   depth_valid;
	logic   depth_ready;
	logic   pick_valid;
	logic   pick_ready;

	always_comb begin
		req.x  = s_axis_tdata[O_X  +: CW];
		req.y  = s_axis_tdata[O_Y  +: CW];
		req.w  = s_axis_tdata[O_W  +: CW-1];
		req.h  = s_axis_tdata[O_H  +: CW-1];
		req.vx = s_axis_tdata[O_VX +: CW];
		req.vy = s_axis_tdata[O_VY +: CW];
		req.wx = s_axis_tdata[O_WX +: CW];
		req.wy = s_axis_tdata[O_WY +: CW];
		req.ww = s_axis_tdata[O_WW +: CW-1];
		req.wh = s_axis_tdata[O_WH +: CW-1];
	end

	acr_depth u_depth (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (req),
		.out_valid (depth_valid),
		.out_ready (depth_ready),
		.out_data  (depth_data)
	);

	acr_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (depth_valid),
		.in_ready  (depth_ready),
		.in_data   (depth_data),
		.out_valid (pick_valid),
		.out_ready (pick_ready),
		.out_data  (pick_data)
	);

	acr_apply u_apply (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pick_valid),
		.in_ready  (pick_ready),
		.in_data   (pick_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res)
	);

	assign m_axis_tdata = OUT_TDATA_W'({res.side, res.vy, res.vx, res.y, res.x});

	// an empty output stage must open the whole chain
	`ACR_ASSERT(a_empty_ready, clk, arst_n, !m_axis_tvalid |-> s_axis_tready)
	`ACR_ASSERT_NEVER(a_top_vy, clk, arst_n,
		m_axis_tvalid && res.side == SIDE_TOP && res.vy > 0)
	`ACR_ASSERT_NEVER(a_bottom_vy, clk, arst_n,
		m_axis_tvalid && res.side == SIDE_BOTTOM && res.vy < 0)
	`ACR_ASSERT_NEVER(a_left_vx, clk, arst_n,
		m_axis_tvalid && res.side == SIDE_LEFT && res.vx > 0)
	`ACR_ASSERT_NEVER(a_right_vx, clk, arst_n,
		m_axis_tvalid && res.side == SIDE_RIGHT && res.vx < 0)

endmodule

// ----- sim/aabb_collision_resolve_test.sv -----
// ----------------------------------------------------------------------------
// aabb_collision_resolve_test
// Self-checking bench for the box collision resolver. Box pairs are streamed
// in with random source gaps and sink stalls. Each accepted request is
// resolved by a behavioral model of the depth pick, velocity clearing and
// saturated push-out. Results are compared field by field in order.
// ----------------------------------------------------------------------------
module aabb_collision_resolve_test;

	timeunit 1ns;
	timeprecision 1ps;

	import acr_pkg::*;

	localparam longint COORD_MAX  = 64'sd8388607;
	localparam longint COORD_MIN  = -64'sd8388608;
	localparam longint SIZE_MAX   = 64'sd8388607;
	localparam int     QUIET_MAX  = 2000;
	localparam int     PHASES     = 4;
	localparam int     PER_PHASE  = 250;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	req_t box_queue[$];
	res_t resolved_queue[$];
	req_t driven_req;
	req_t popped_req;
	int   send_gap;
	int   recv_stall;
	int   quiet_cycles;
	int   mismatches;
	bit   calm;

	aabb_collision_resolve u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// behavioral model
	// ------------------------------------------------------------------
	function automatic bit strictly_least(longint a, longint b, longint c, longint d);
		return a < b && a < c && a < d;
	endfunction

	// depth rounded up to whole units, nothing when not overlapping
	function automatic longint unit_push(longint depth);
		longint unit;
		unit = longint'(1) << FB;
		if (depth <= 0)
			return 0;
		return ((depth + unit - 1) / unit) * unit;
	endfunction

	function automatic longint clamp_coord(longint v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	function automatic res_t resolve_pair(req_t r);
		longint x, y, vx, vy, d_top, d_bot, d_left, d_right;
		res_t o;
		x  = longint'(r.x);
		y  = longint'(r.y);
		vx = longint'(r.vx);
		vy = longint'(r.vy);
		d_top   = y + longint'(r.h) - longint'(r.wy);
		d_bot   = longint'(r.wy) + longint'(r.wh) - y;
		d_left  = x + longint'(r.w) - longint'(r.wx);
		d_right = longint'(r.wx) + longint'(r.ww) - x;
		o.side = SIDE_NONE;
		if (strictly_least(d_top, d_bot, d_left, d_right)) begin
			o.side = SIDE_TOP;
			if (vy > 0)
				vy = 0;
			y = clamp_coord(y - unit_push(d_top));
		end else if (strictly_least(d_bot, d_top, d_left, d_right)) begin
			o.side = SIDE_BOTTOM;
			if (vy < 0)
				vy = 0;
			y = clamp_coord(y + unit_push(d_bot));
		end else if (strictly_least(d_left, d_right, d_top, d_bot)) begin
			o.side = SIDE_LEFT;
			if (vx > 0)
				vx = 0;
			x = clamp_coord(x - unit_push(d_left));
		end else if (strictly_least(d_right, d_left, d_top, d_bot)) begin
			o.side = SIDE_RIGHT;
			if (vx < 0)
				vx = 0;
			x = clamp_coord(x + unit_push(d_right));
		end
		o.x  = x[CW-1:0];
		o.y  = y[CW-1:0];
		o.vx = vx[CW-1:0];
		o.vy = vy[CW-1:0];
		return o;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [IN_TDATA_W-1:0] pack_request(req_t r);
		logic [IN_TDATA_W-1:0] d;
		d = '0;
		d[O_X  +: CW]     = r.x;
		d[O_Y  +: CW]     = r.y;
		d[O_W  +: CW - 1] = r.w;
		d[O_H  +: CW - 1] = r.h;
		d[O_VX +: CW]     = r.vx;
		d[O_VY +: CW]     = r.vy;
		d[O_WX +: CW]     = r.wx;
		d[O_WY +: CW]     = r.wy;
		d[O_WW +: CW - 1] = r.ww;
		d[O_WH +: CW - 1] = r.wh;
		return d;
	endfunction

	task automatic add_box(longint x, longint y, longint w, longint h, longint vx,
			longint vy, longint wx, longint wy, longint ww, longint wh);
		req_t r;
		r.x  = x[CW-1:0];
		r.y  = y[CW-1:0];
		r.w  = w[CW-2:0];
		r.h  = h[CW-2:0];
		r.vx = vx[CW-1:0];
		r.vy = vy[CW-1:0];
		r.wx = wx[CW-1:0];
		r.wy = wy[CW-1:0];
		r.ww = ww[CW-2:0];
		r.wh = wh[CW-2:0];
		box_queue.push_back(r);
	endtask

	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// full range with extra weight on the ends
	function automatic longint any_coord();
		longint v;
		case ($urandom_range(0, 9))
			0: v = COORD_MIN + $urandom_range(0, 4096);
			1: v = COORD_MAX - $urandom_range(0, 4096);
			default: begin
				v = $urandom_range(0, 16777215);
				v = v - 8388608;
			end
		endcase
		return v;
	endfunction

	function automatic longint any_size();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(0, 8388607);
		return $urandom_range(0, 8192);
	endfunction

	task automatic add_random_box();
		longint mx, my, mw, mh, wx, wy, ww, wh;
		int kind;
		kind = $urandom_range(0, 99);
		wx = any_coord();
		wy = any_coord();
		if (kind < 20) begin
			add_box(any_coord(), any_coord(), $urandom_range(0, 8388607),
				$urandom_range(0, 8388607), any_coord(), any_coord(), wx, wy,
				$urandom_range(0, 8388607), $urandom_range(0, 8388607));
		end else if (kind < 26) begin
			// mover exactly on top of the wall, top/bottom and left/right depths tie
			ww = any_size();
			wh = any_size();
			add_box(wx, wy, ww, wh, any_coord(), any_coord(), wx, wy, ww, wh);
		end else begin
			// overlapping or just touching pair
			ww = any_size();
			wh = any_size();
			mw = any_size();
			mh = any_size();
			mx = wx - mw + $urandom_range(0, mw + ww);
			my = wy - mh + $urandom_range(0, mh + wh);
			add_box(mx, my, mw, mh, any_coord(), any_coord(), wx, wy, ww, wh);
		end
	endtask

	// ------------------------------------------------------------------
	// request driver
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			send_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				resolved_queue.push_back(resolve_pair(driven_req));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					send_gap      <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (box_queue.size() != 0) begin
					popped_req     = box_queue.pop_front();
					driven_req    <= popped_req;
					s_axis_tdata  <= pack_request(popped_req);
					s_axis_tvalid <= 1'b1;
					send_gap      <= pick_gap(calm);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result sink and checker
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall    <= 0;
		end else if (recv_stall != 0) begin
			recv_stall    <= recv_stall - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			recv_stall    <= pick_gap(calm);
		end
	end

	always @(posedge clk) begin : result_check
		res_t                 want;
		logic signed [CW-1:0] got_x, got_y, got_vx, got_vy;
		logic [2:0]           got_side;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_x    = m_axis_tdata[0 +: CW];
			got_y    = m_axis_tdata[CW +: CW];
			got_vx   = m_axis_tdata[2 * CW +: CW];
			got_vy   = m_axis_tdata[3 * CW +: CW];
			got_side = m_axis_tdata[4 * CW +: 3];
			if (resolved_queue.size() == 0) begin
				$error("result with no request outstanding: new_x %0d new_y %0d hit_side %0d",
					got_x, got_y, got_side);
				mismatches++;
			end else begin
				want = resolved_queue.pop_front();
				if (got_x !== want.x) begin
					$error("new_x: expected %0d, got %0d", want.x, got_x);
					mismatches++;
				end
				if (got_y !== want.y) begin
					$error("new_y: expected %0d, got %0d", want.y, got_y);
					mismatches++;
				end
				if (got_vx !== want.vx) begin
					$error("new_vx: expected %0d, got %0d", want.vx, got_vx);
					mismatches++;
				end
				if (got_vy !== want.vy) begin
					$error("new_vy: expected %0d, got %0d", want.vy, got_vy);
					mismatches++;
				end
				if (got_side !== want.side) begin
					$error("hit_side: expected %0d, got %0d", want.side, got_side);
					mismatches++;
				end
			end
		end
	end

	// no handshake on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_MAX) begin
			$display("aabb_collision_resolve_test: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		mismatches = 0;
		calm       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// all zero and identical boxes: four-way tie
		add_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_box(512, 512, 256, 256, 300, -300, 512, 512, 256, 256);
		// one clean hit per side, velocity heading in
		add_box(400, -100, 200, 110, 500, 500, 0, 0, 1000, 1000);
		add_box(400, 990, 200, 200, -500, -500, 0, 0, 1000, 1000);
		add_box(-100, 400, 110, 200, 500, 500, 0, 0, 1000, 1000);
		add_box(990, 400, 200, 200, -500, -500, 0, 0, 1000, 1000);
		// hits with velocity heading away, left untouched
		add_box(400, -100, 200, 110, -700, -700, 0, 0, 1000, 1000);
		add_box(990, 400, 200, 200, 700, 700, 0, 0, 1000, 1000);
		// depth of exactly one unit and one unit plus a fraction
		add_box(400, -256, 200, 512, 1, 1, 0, 0, 2000, 2000);
		add_box(400, -257, 200, 514, 1, 1, 0, 0, 2000, 2000);
		// no overlap: side still reported, box not moved
		add_box(400, -5000, 200, 100, 900, 900, 0, 0, 1000, 1000);
		add_box(-5000, 400, 100, 200, 900, -900, 0, 0, 1000, 1000);
		// push-out that saturates on each edge of the coordinate range
		add_box(0, COORD_MIN, 10, 1000, 5, 5, -1000, COORD_MIN + 500, 100000, 100000);
		add_box(0, COORD_MAX - 100, 10, 300, -5, -5, -1000, COORD_MAX - 1000,
			100000, 1000);
		add_box(COORD_MIN, 0, 1000, 10, 5, 5, COORD_MIN + 500, -1000, 100000, 100000);
		add_box(COORD_MAX - 100, 0, 300, 10, -5, -5, COORD_MAX - 1000, -1000,
			1000, 100000);
		// two smallest depths equal: vertical, horizontal, corner
		add_box(-1000, 100, 3000, 100, 1, 1, 0, 0, 300, 300);
		add_box(100, -1000, 100, 3000, 1, 1, 0, 0, 300, 300);
		add_box(-50, -50, 100, 100, 1, 1, 0, 0, 1000, 1000);
		// field extremes
		add_box(COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, COORD_MAX, COORD_MAX,
			COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX);
		add_box(COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, COORD_MIN, COORD_MIN,
			COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX);
		add_box(COORD_MIN, COORD_MAX, 0, SIZE_MAX, COORD_MIN, COORD_MAX,
			COORD_MIN, COORD_MAX, SIZE_MAX, 0);
		add_box(-1, -1, 1, 1, -1, -1, -1, -1, 1, 1);

		for (int p = 0; p < PHASES; p++) begin
			calm = (p == 2);
			for (int i = 0; i < PER_PHASE; i++)
				add_random_box();
			while (box_queue.size() != 0)
				@(posedge clk);
		end

		while (box_queue.size() != 0 || s_axis_tvalid || resolved_queue.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("aabb_collision_resolve_test: PASS");
		else
			$display("aabb_collision_resolve_test: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/acr_pkg.sv
src/acr_depth.sv
src/acr_select.sv
src/acr_apply.sv
src/aabb_collision_resolve.sv
sim/aabb_collision_resolve_test.sv
